// File: rtl/core/aes_pkg.sv
// AES-128 package: S-box tables, round constants and GF(2^8) helpers.
// Used by the round-key memory controller, the round unit and the top level.
package aes_pkg;

    localparam int ROUNDS_DEF = 10;
    localparam int KEY_WIDTH  = 64;
    localparam int BLK_WIDTH  = 64;

    // Configuration register indexes.
    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    // Command codes.
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // Key schedule status passed from the key unit to the datapath.
    typedef struct packed {
        logic busy;
    } key_status_t;

    function automatic logic [7:0] fwd_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
            8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
            8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
            8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
            8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
            8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
            8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
            8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
            8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
            8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
            8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
            8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
            8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
            8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
            8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
            8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
            8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        return t[x];
    endfunction

    // Round constant for schedule round r (indexes above 10 give 8'h8d, as index 0 does).
    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        v = 8'h00;
        unique case (r)
            4'd0:    v = 8'h8d;
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h8d;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {fwd_sbox(w[31:24]), fwd_sbox(w[23:16]), fwd_sbox(w[15:8]), fwd_sbox(w[7:0])};
    endfunction

endpackage

// File: rtl/core/aes_stream_if.sv
// Valid/ready stream interface carrying AES command and block halves.
// Depends on nothing but a clock domain of the user.
interface aes_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [63:0] block_high;
    logic [63:0] block_low;
    modport source (output valid, command, block_high, block_low, input ready);
    modport sink   (input valid, command, block_high, block_low, output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;
    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface

// File: rtl/core/aes_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Self-contained; used for the round-key schedule.
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 44
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/aes_keysched.sv
// Round-key schedule: key registers and an expansion sequencer that writes
// 44 words into the schedule RAM, one word a cycle. Uses aes_pkg and aes_ram.
module aes_keysched #(
    parameter int ROUNDS = aes_pkg::ROUNDS_DEF,
    localparam int WORDS = 4 * (ROUNDS + 1),
    localparam int AW    = $clog2(WORDS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [0:0]           cfg_sel,
    input  logic                 cfg_in_range,
    input  logic [63:0]          cfg_data,
    input  logic [AW-1:0]        rk_addr,
    output logic [31:0]          rk_word,
    output aes_pkg::key_status_t status
);
    logic [63:0]   key_high_reg, key_high_next;
    logic [63:0]   key_low_reg, key_low_next;
    logic          busy_reg, busy_next;
    logic [AW-1:0] widx_reg, widx_next;
    // Last four generated words, w[i-4] in slot 0 and w[i-1] in slot 3.
    logic [31:0]   win_reg [4];
    logic [31:0]   win_next [4];
    logic [31:0]   new_word;
    logic [31:0]   t;
    logic          we;
    logic [AW-1:0] raddr;

    // Next schedule word from the sliding window.
    always_comb
    begin
        t = win_reg[3];
        if (widx_reg[1:0] == 2'd0)
        begin
            t = aes_pkg::sub_word({win_reg[3][23:0], win_reg[3][31:24]})
                ^ {aes_pkg::rcon(4'(widx_reg >> 2)), 24'h0};
        end
        if (widx_reg < AW'(4))
        begin
            unique case (widx_reg[1:0])
                2'd0:    new_word = key_high_reg[63:32];
                2'd1:    new_word = key_high_reg[31:0];
                2'd2:    new_word = key_low_reg[63:32];
                default: new_word = key_low_reg[31:0];
            endcase
        end
        else
        begin
            new_word = win_reg[0] ^ t;
        end
    end

    // Sequencer control and key register update.
    always_comb
    begin
        key_high_next = key_high_reg;
        key_low_next  = key_low_reg;
        busy_next     = busy_reg;
        widx_next     = widx_reg;
        win_next      = win_reg;
        if (busy_reg)
        begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = win_reg[3];
            win_next[3] = new_word;
            widx_next   = widx_reg + AW'(1);
            if (widx_reg == AW'(WORDS - 1))
            begin
                busy_next = 1'b0;
            end
        end
        if (cfg_write && cfg_in_range)
        begin
            if (cfg_sel == aes_pkg::REG_KEY_HIGH)
            begin
                key_high_next = cfg_data;
            end
            else
            begin
                key_low_next = cfg_data;
            end
            busy_next = 1'b1;
            widx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            busy_reg     <= 1'b1;
            widx_reg     <= '0;
        end
        else
        begin
            key_high_reg <= key_high_next;
            key_low_reg  <= key_low_next;
            busy_reg     <= busy_next;
            widx_reg     <= widx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    assign we            = busy_reg;
    assign raddr         = rk_addr;
    assign status.busy   = busy_reg;

    aes_ram #(.WIDTH(32), .DEPTH(WORDS)) u_sched_ram (
        .clk   (clk),
        .we    (we),
        .waddr (widx_reg),
        .wdata (new_word),
        .raddr (raddr),
        .rdata (rk_word)
    );
endmodule

// File: rtl/core/aes_round.sv
// Shared AES round datapath: forward or inverse SubBytes/ShiftRows, MixColumns
// and round-key addition on a 128-bit state. Uses aes_pkg.
module aes_round (
    input  logic [127:0] state_in,
    input  logic [127:0] rkey,
    input  logic         decrypt,
    input  logic         key_only,
    input  logic         last,
    output logic [127:0] state_out
);
    logic [7:0] s [16];
    logic [7:0] ss [16];
    logic [7:0] m [16];
    logic [7:0] k [16];
    logic [7:0] o [16];
    logic [7:0] a0, a1, a2, a3, x2, x4, x8;
    logic [7:0] b0, b1, b2, b3;

    always_comb
    begin
        a0 = 8'h00;
        a1 = 8'h00;
        a2 = 8'h00;
        a3 = 8'h00;
        x4 = 8'h00;
        x8 = 8'h00;
        for (int n = 0; n < 16; n++)
        begin
            s[n] = state_in[127-8*n -: 8];
            k[n] = rkey[127-8*n -: 8];
        end
        // Substitution with row rotation; byte r+4c is row r, column c.
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (decrypt)
                begin
                    ss[r + 4*((c + r) % 4)] = aes_pkg::inv_sbox(s[r + 4*c]);
                end
                else
                begin
                    ss[r + 4*c] = aes_pkg::fwd_sbox(s[r + 4*((c + r) % 4)]);
                end
            end
        end
        // Column mixing; decryption adds the key before mixing.
        for (int c = 0; c < 4; c++)
        begin
            if (decrypt)
            begin
                a0 = ss[4*c] ^ k[4*c];
                a1 = ss[4*c+1] ^ k[4*c+1];
                a2 = ss[4*c+2] ^ k[4*c+2];
                a3 = ss[4*c+3] ^ k[4*c+3];
                // Inverse mix as preconditioning then forward mix.
                x2 = aes_pkg::xtime(a0 ^ a2);
                x4 = aes_pkg::xtime(x2);
                x8 = aes_pkg::xtime(a1 ^ a3);
                x8 = aes_pkg::xtime(x8);
                b0 = a0 ^ x4;
                b1 = a1 ^ x8;
                b2 = a2 ^ x4;
                b3 = a3 ^ x8;
            end
            else
            begin
                b0 = ss[4*c];
                b1 = ss[4*c+1];
                b2 = ss[4*c+2];
                b3 = ss[4*c+3];
            end
            x2 = b0 ^ b1 ^ b2 ^ b3;
            m[4*c]   = b0 ^ x2 ^ aes_pkg::xtime(b0 ^ b1);
            m[4*c+1] = b1 ^ x2 ^ aes_pkg::xtime(b1 ^ b2);
            m[4*c+2] = b2 ^ x2 ^ aes_pkg::xtime(b2 ^ b3);
            m[4*c+3] = b3 ^ x2 ^ aes_pkg::xtime(b3 ^ b0);
        end
        for (int n = 0; n < 16; n++)
        begin
            if (key_only)
            begin
                o[n] = s[n] ^ k[n];
            end
            else if (last)
            begin
                o[n] = ss[n] ^ k[n];
            end
            else if (decrypt)
            begin
                o[n] = m[n];
            end
            else
            begin
                o[n] = m[n] ^ k[n];
            end
        end
        for (int n = 0; n < 16; n++)
        begin
            state_out[127-8*n -: 8] = o[n];
        end
    end
endmodule

// File: rtl/core/aes128_block_cipher.sv
// Top level of the AES-128 ECB cipher: handshakes, round sequencer and
// output register. Uses aes_pkg, aes_stream_if, aes_keysched and aes_round.
//
// Usage: write the key through cfg_we/cfg_index/cfg_data (index 0 is key
// bytes 0..7, index 1 key bytes 8..15). Each write re-expands the schedule
// into 4*(ROUNDS+1) words; no input beat is taken meanwhile.
// After reset the schedule of the all-zero key is built in the same way, so
// in_ch.ready stays low until that expansion is complete.
// Input beats on in_ch carry a command (0 encrypt, 1 decrypt) and a block;
// output beats on out_ch carry the result in the same byte order.
// Round keys are read from the schedule RAM one word a cycle: each of the
// 11 round steps fetches its four words in ST_FETCH (the RAM read is
// registered) and then applies the round in ST_APPLY. After the last step
// ST_DONE loads the result into the output register, and the next input
// beat can be taken once the sequencer is back in ST_IDLE. The block works
// on one beat at a time. The result waits in an output register; the next
// beat is accepted while it waits, and the sequencer stalls at its end
// only if the previous result is still untaken.
module aes128_block_cipher #(
    parameter int ROUNDS = aes_pkg::ROUNDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data,
    aes_in_if.sink      in_ch,
    aes_out_if.source   out_ch
);
    localparam int WORDS = 4 * (ROUNDS + 1);
    localparam int AW    = $clog2(WORDS);
    localparam int RW    = $clog2(ROUNDS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]   st_reg, st_next;
    logic [127:0] state_reg, state_next;
    logic [127:0] rkey_reg, rkey_next;
    logic         dec_reg, dec_next;
    logic [RW-1:0] step_reg, step_next;
    logic [2:0]   widx_reg, widx_next;
    logic         ovalid_reg, ovalid_next;
    logic [127:0] obuf_reg, obuf_next;
    logic [AW-1:0] rk_addr;
    logic [31:0]  rk_word;
    logic [RW-1:0] kround;
    logic [127:0] round_out;
    logic         key_only, last;
    aes_pkg::key_status_t ks;

    aes_keysched #(.ROUNDS(ROUNDS)) u_keysched (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_we),
        .cfg_sel      (cfg_index),
        .cfg_in_range (1'b1),
        .cfg_data     (cfg_data),
        .rk_addr      (rk_addr),
        .rk_word      (rk_word),
        .status       (ks)
    );

    // Round number whose key is used at this step.
    assign kround   = dec_reg ? RW'(ROUNDS) - step_reg : step_reg;
    assign rk_addr  = AW'({kround, 2'b00}) + AW'(widx_reg[1:0]);
    assign key_only = (step_reg == '0);
    assign last     = (step_reg == RW'(ROUNDS));

    aes_round u_round (
        .state_in  (state_reg),
        .rkey      (rkey_reg),
        .decrypt   (dec_reg),
        .key_only  (key_only),
        .last      (last),
        .state_out (round_out)
    );

    assign in_ch.ready        = (st_reg == ST_IDLE) && !ks.busy;
    assign out_ch.valid       = ovalid_reg;
    assign out_ch.result_high = obuf_reg[127:64];
    assign out_ch.result_low  = obuf_reg[63:0];

    // Sequencer: fetch four key words (registered RAM read), then apply.
    always_comb
    begin
        st_next     = st_reg;
        state_next  = state_reg;
        rkey_next   = rkey_reg;
        dec_next    = dec_reg;
        step_next   = step_reg;
        widx_next   = widx_reg;
        ovalid_next = ovalid_reg;
        obuf_next   = obuf_reg;
        if (out_ch.valid && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    state_next = {in_ch.block_high, in_ch.block_low};
                    dec_next   = (in_ch.command == aes_pkg::CMD_DECRYPT);
                    step_next  = '0;
                    widx_next  = '0;
                    st_next    = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                // Word widx-1 arrives now from the read issued last cycle.
                if (widx_reg != 3'd0)
                begin
                    rkey_next = {rkey_reg[95:0], rk_word};
                end
                widx_next = widx_reg + 3'd1;
                if (widx_reg == 3'd4)
                begin
                    st_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = round_out;
                widx_next  = '0;
                if (last)
                begin
                    st_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + RW'(1);
                    st_next   = ST_FETCH;
                end
            end
            default:
            begin
                if (!ovalid_next)
                begin
                    ovalid_next = 1'b1;
                    obuf_next   = state_reg;
                    st_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            ovalid_reg <= 1'b0;
            step_reg   <= '0;
            widx_reg   <= '0;
        end
        else
        begin
            st_reg     <= st_next;
            ovalid_reg <= ovalid_next;
            step_reg   <= step_next;
            widx_reg   <= widx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        rkey_reg  <= rkey_next;
        dec_reg   <= dec_next;
        obuf_reg  <= obuf_next;
    end
endmodule

// File: sim/aes128_block_cipher_tb.sv
// Self-checking testbench for the AES-128 ECB cipher top level.
// Needs aes_pkg, aes_in_if/aes_out_if and the aes128_block_cipher RTL;
// results are predicted by a behavioral AES model kept inside this file.
module aes128_block_cipher_tb;

    localparam int  NUM_RANDOM  = 1800;
    localparam int  QUIET_TAIL  = 150;
    localparam int  SETTLE_CYC  = 12;
    localparam longint LIMIT    = 2000000;

    typedef enum logic [1:0] { OP_BLOCK, OP_KEYWR, OP_SETTLE } op_kind_t;

    typedef struct {
        op_kind_t    kind;
        logic        command;
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [0:0]  reg_index;
    } pending_op_t;

    typedef struct {
        logic [63:0] high;
        logic [63:0] low;
    } cipher_block_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_data;

    aes_in_if  in_ch ();
    aes_out_if out_ch ();

    aes128_block_cipher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    pending_op_t   op_queue [$];
    cipher_block_t expected_blocks [$];

    logic [7:0]  sbox_fwd [256];
    logic [7:0]  sbox_inv [256];
    logic [63:0] model_key_high;
    logic [63:0] model_key_low;
    logic [31:0] sched_words [44];

    int     beats_issued;
    int     beats_taken;
    int     blocks_queued;
    int     errors;
    int     in_gap;
    int     out_gap;
    int     settle_count;
    longint cycle_count;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // GF(2^8) multiply with the AES polynomial.
    function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc = acc ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // Build both substitution tables from the field inverse and the affine map.
    function automatic void build_sboxes();
        logic [7:0] inv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (x != 0 && gf_mult(x[7:0], y[7:0]) == 8'h01)
                    inv = y[7:0];
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sbox_fwd[x] = s;
            sbox_inv[s] = x[7:0];
        end
    endfunction

    // Expand the 128-bit key into the 44-word schedule.
    function automatic void expand_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        sched_words[0] = model_key_high[63:32];
        sched_words[1] = model_key_high[31:0];
        sched_words[2] = model_key_low[63:32];
        sched_words[3] = model_key_low[31:0];
        rc = 8'h01;
        for (int i = 4; i < 44; i++)
        begin
            t = sched_words[i-1];
            if (i % 4 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {sbox_fwd[t[31:24]], sbox_fwd[t[23:16]], sbox_fwd[t[15:8]],
                     sbox_fwd[t[7:0]]} ^ {rc, 24'h0};
                rc = gf_mult(rc, 8'h02);
            end
            sched_words[i] = sched_words[i-4] ^ t;
        end
    endfunction

    // Encrypt or decrypt one block with the current schedule.
    function automatic cipher_block_t aes_transform(input logic decrypt,
                                                    input logic [63:0] hi,
                                                    input logic [63:0] lo);
        logic [7:0]    s [16];
        logic [7:0]    t [16];
        logic [7:0]    a [4];
        logic [7:0]    m [4];
        logic [127:0]  blk;
        logic [31:0]   w;
        int            rnd;
        int            step;
        cipher_block_t res;
        blk = {hi, lo};
        for (int n = 0; n < 16; n++)
            s[n] = blk[127 - 8*n -: 8];
        if (decrypt)
            m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (step = 0; step <= 10; step++)
        begin
            rnd = decrypt ? 10 - step : step;
            // Forward: substitute and shift, then mix (not in the last round), before the key.
            if (step > 0 && !decrypt)
            begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[r + 4*c] = sbox_fwd[s[r + 4*((c + r) % 4)]];
                s = t;
                if (step < 10)
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int k = 0; k < 4; k++)
                            a[k] = s[4*c + k];
                        for (int r = 0; r < 4; r++)
                        begin
                            s[4*c + r] = 8'h00;
                            for (int k = 0; k < 4; k++)
                                s[4*c + r] ^= gf_mult(a[k], m[(k + 4 - r) % 4]);
                        end
                    end
            end
            // Inverse: shift back and substitute before the key.
            if (step > 0 && decrypt)
            begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[r + 4*((c + r) % 4)] = sbox_inv[s[r + 4*c]];
                s = t;
            end
            for (int c = 0; c < 4; c++)
            begin
                w = sched_words[4*rnd + c];
                for (int r = 0; r < 4; r++)
                    s[4*c + r] ^= w[31 - 8*r -: 8];
            end
            // Inverse mix follows the key in the middle rounds.
            if (decrypt && step > 0 && step < 10)
                for (int c = 0; c < 4; c++)
                begin
                    for (int k = 0; k < 4; k++)
                        a[k] = s[4*c + k];
                    for (int r = 0; r < 4; r++)
                    begin
                        s[4*c + r] = 8'h00;
                        for (int k = 0; k < 4; k++)
                            s[4*c + r] ^= gf_mult(a[k], m[(k + 4 - r) % 4]);
                    end
                end
        end
        for (int n = 0; n < 16; n++)
            blk[127 - 8*n -: 8] = s[n];
        res.high = blk[127:64];
        res.low  = blk[63:0];
        return res;
    endfunction

    function automatic void add_block(input logic cmd, input logic [63:0] hi,
                                      input logic [63:0] lo);
        pending_op_t op;
        op.kind = OP_BLOCK;
        op.command = cmd;
        op.data_high = hi;
        op.data_low = lo;
        op.reg_index = aes_pkg::REG_KEY_HIGH;
        op_queue.push_back(op);
        blocks_queued++;
    endfunction

    // A key write is always preceded by a drain of the block.
    function automatic void add_key(input logic [63:0] kh, input logic [63:0] kl);
        pending_op_t op;
        op.kind = OP_SETTLE;
        op.command = aes_pkg::CMD_ENCRYPT;
        op.data_high = '0;
        op.data_low = '0;
        op.reg_index = aes_pkg::REG_KEY_HIGH;
        op_queue.push_back(op);
        op.kind = OP_KEYWR;
        op.data_high = kh;
        op_queue.push_back(op);
        op.reg_index = aes_pkg::REG_KEY_LOW;
        op.data_high = kl;
        op_queue.push_back(op);
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 7))
            0: return 64'h0;
            1: return {64{1'b1}};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Reset and stimulus generation, then the end-of-run check.
    initial
    begin
        pending_op_t drain;
        rst_n = 1'b0;
        errors = 0;
        blocks_queued = 0;
        build_sboxes();
        model_key_high = '0;
        model_key_low = '0;
        expand_schedule();

        // Before any key write the all-zero key applies.
        add_block(aes_pkg::CMD_ENCRYPT, 64'h0, 64'h0);
        add_block(aes_pkg::CMD_DECRYPT, 64'h0, 64'h0);
        add_block(aes_pkg::CMD_ENCRYPT, {64{1'b1}}, {64{1'b1}});
        // Standard test key and plaintext, both directions.
        add_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        add_block(aes_pkg::CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        add_block(aes_pkg::CMD_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        add_block(aes_pkg::CMD_DECRYPT, {64{1'b1}}, 64'h0);
        // Rewriting the same key must leave the schedule unchanged.
        add_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        add_block(aes_pkg::CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        add_key({64{1'b1}}, {64{1'b1}});
        add_block(aes_pkg::CMD_ENCRYPT, 64'h0, {64{1'b1}});
        add_block(aes_pkg::CMD_DECRYPT, 64'h8000000000000000, 64'h1);
        add_key(64'h0, {64{1'b1}});
        add_block(aes_pkg::CMD_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
        add_block(aes_pkg::CMD_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);

        // Random blocks; the key changes every few hundred beats.
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i % 300 == 150)
                add_key(rand64(), rand64());
            if (i == 900)
            begin
                drain.kind = OP_SETTLE;
                drain.command = aes_pkg::CMD_ENCRYPT;
                drain.data_high = '0;
                drain.data_low = '0;
                drain.reg_index = aes_pkg::REG_KEY_HIGH;
                op_queue.push_back(drain);
            end
            add_block(1'($urandom_range(0, 1)), rand64(), rand64());
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (op_queue.size() == 0 && beats_taken == beats_issued
              && expected_blocks.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_blocks.size() == 0)
            $display("aes128_block_cipher_tb OK");
        else
            $display("aes128_block_cipher_tb NOT OK");
        $finish;
    end

    // Input driver: one decision per falling edge.
    always @(negedge clk or negedge rst_n)
    begin
        logic        v_n;
        logic        we_n;
        logic        quiet;
        pending_op_t op;
        if (!rst_n)
        begin
            in_ch.valid      <= 1'b0;
            in_ch.command    <= aes_pkg::CMD_ENCRYPT;
            in_ch.block_high <= '0;
            in_ch.block_low  <= '0;
            cfg_we           <= 1'b0;
            cfg_index        <= aes_pkg::REG_KEY_HIGH;
            cfg_data         <= '0;
            beats_issued     <= 0;
            in_gap           <= 0;
            settle_count     <= 0;
        end
        else
        begin
            quiet = (blocks_queued - beats_issued) < QUIET_TAIL;
            we_n = 1'b0;
            v_n = in_ch.valid;
            if (in_ch.valid && beats_issued != beats_taken)
                v_n = 1'b1;
            else if (in_gap > 0)
            begin
                v_n = 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (op_queue.size() > 0)
            begin
                op = op_queue[0];
                v_n = 1'b0;
                case (op.kind)
                    OP_BLOCK:
                    begin
                        if (!quiet && $urandom_range(0, 5) == 0)
                            in_gap <= $urandom_range(1, 10);
                        else
                        begin
                            v_n = 1'b1;
                            in_ch.command    <= op.command;
                            in_ch.block_high <= op.data_high;
                            in_ch.block_low  <= op.data_low;
                            beats_issued     <= beats_issued + 1;
                            void'(op_queue.pop_front());
                        end
                    end
                    OP_KEYWR:
                    begin
                        we_n = 1'b1;
                        cfg_index <= op.reg_index;
                        cfg_data  <= op.data_high;
                        void'(op_queue.pop_front());
                    end
                    default:
                    begin
                        // Wait for the block to drain fully before going on.
                        if (expected_blocks.size() == 0 && beats_taken == beats_issued)
                        begin
                            if (settle_count >= SETTLE_CYC)
                            begin
                                settle_count <= 0;
                                void'(op_queue.pop_front());
                            end
                            else
                                settle_count <= settle_count + 1;
                        end
                    end
                endcase
            end
            else
                v_n = 1'b0;
            in_ch.valid <= v_n;
            cfg_we <= we_n;
        end
    end

    // Result-side backpressure in random bursts.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap <= 0;
        end
        else if (out_gap > 0)
        begin
            out_ch.ready <= 1'b0;
            out_gap <= out_gap - 1;
        end
        else if ((blocks_queued - beats_issued) >= QUIET_TAIL && $urandom_range(0, 5) == 0)
        begin
            out_ch.ready <= 1'b0;
            out_gap <= $urandom_range(0, 9);
        end
        else
            out_ch.ready <= 1'b1;
    end

    // Monitor: track key writes and input beats, check each result beat.
    always @(posedge clk or negedge rst_n)
    begin
        cipher_block_t want;
        if (!rst_n)
        begin
            beats_taken <= 0;
            cycle_count <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cfg_we)
            begin
                if (cfg_index == aes_pkg::REG_KEY_HIGH)
                    model_key_high = cfg_data;
                else
                    model_key_low = cfg_data;
                expand_schedule();
            end
            if (in_ch.valid && in_ch.ready)
            begin
                expected_blocks.push_back(
                    aes_transform(in_ch.command == aes_pkg::CMD_DECRYPT,
                                  in_ch.block_high, in_ch.block_low));
                beats_taken <= beats_taken + 1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_blocks.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h_%h", $time,
                             out_ch.result_high, out_ch.result_low);
                    errors++;
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (out_ch.result_high !== want.high)
                    begin
                        $display("%0t: result_high expected %h actual %h", $time,
                                 want.high, out_ch.result_high);
                        errors++;
                    end
                    if (out_ch.result_low !== want.low)
                    begin
                        $display("%0t: result_low expected %h actual %h", $time,
                                 want.low, out_ch.result_low);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        if (cycle_count > LIMIT)
        begin
            $display("aes128_block_cipher_tb NOT OK");
            $finish;
        end
    end

endmodule

// File: files.f
rtl/core/aes_pkg.sv
rtl/core/aes_stream_if.sv
rtl/core/aes_ram.sv
rtl/core/aes_keysched.sv
rtl/core/aes_round.sv
rtl/core/aes128_block_cipher.sv
sim/aes128_block_cipher_tb.sv
